### design/ismu_pkg.sv
// ----------------------------------------------------------------------------
// ismu_pkg
// Shared types, command codes and constants of the Ising spin update block.
// ----------------------------------------------------------------------------
`default_nettype none

package ismu_pkg;

	localparam int SIDE_DEFAULT = 64;

	localparam int CMD_W  = 2;
	localparam int POS_W  = 6;
	localparam int POS_N  = 1 << POS_W;
	localparam int RAND_W = 16;
	localparam int THR_W  = 16;
	localparam int DE_W   = 5;

	localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

	localparam logic CFG_THR_DELTA4 = 1'b0;
	localparam logic CFG_THR_DELTA8 = 1'b1;

	localparam logic [THR_W-1:0] THR_DELTA4_RST = 16'd11252;
	localparam logic [THR_W-1:0] THR_DELTA8_RST = 16'd1932;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD1,
		ST_RD2,
		ST_RD3,
		ST_DEC
	} state_t;

	typedef struct packed {
		logic                   flip;
		logic                   new_spin;
		logic signed [DE_W-1:0] de;
	} flip_res_t;

endpackage

`default_nettype wire

### design/ismu_lattice_mem.sv
// ----------------------------------------------------------------------------
// ismu_lattice_mem
// Spin lattice store: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ismu_lattice_mem #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  wire logic          clk,
	input  wire logic          re,
	input  wire logic [AW-1:0] ra_a,
	input  wire logic [AW-1:0] ra_b,
	input  wire logic          we,
	input  wire logic [AW-1:0] wa,
	input  wire logic          wd,
	output logic               rd_a,
	output logic               rd_b
);

	logic lattice_mem [DEPTH];
	logic rd_a_q;
	logic rd_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			lattice_mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_a_q <= lattice_mem[ra_a];
			rd_b_q <= lattice_mem[ra_b];
		end
	end

	assign rd_a = rd_a_q;
	assign rd_b = rd_b_q;

endmodule

`default_nettype wire

### design/ismu_flip_decide.sv
// ----------------------------------------------------------------------------
// ismu_flip_decide
// Neighbor sum, energy change and Metropolis acceptance for one site.
// ----------------------------------------------------------------------------
`default_nettype none

module ismu_flip_decide
	import ismu_pkg::*;
(
	input  wire logic [CMD_W-1:0]  cmd,
	input  wire logic              spin_in,
	input  wire logic              center,
	input  wire logic              up,
	input  wire logic              dn,
	input  wire logic              lf,
	input  wire logic              rt,
	input  wire logic [RAND_W-1:0] rand_u,
	input  wire logic [THR_W-1:0]  thr4,
	input  wire logic [THR_W-1:0]  thr8,
	output flip_res_t              res
);

	logic [2:0]        n_up;
	logic signed [5:0] four_n;
	logic signed [5:0] de_w;
	logic              is_upd;
	logic              accept;

	assign n_up   = 3'(up) + 3'(dn) + 3'(lf) + 3'(rt);
	assign four_n = signed'({1'b0, n_up, 2'b00});
	// s=+1: dE = 4n-8, s=-1: dE = 8-4n
	assign de_w   = center ? (four_n - 6'sd8) : (6'sd8 - four_n);
	assign is_upd = (cmd == CMD_UPDATE);

	always_comb begin
		if (de_w <= 6'sd0) begin
			accept = 1'b1;
		end else if (de_w == 6'sd4) begin
			accept = (rand_u < thr4);
		end else if (de_w == 6'sd8) begin
			accept = (rand_u < thr8);
		end else begin
			accept = 1'b0;
		end
	end

	always_comb begin
		res.flip     = is_upd && accept;
		res.de       = is_upd ? signed'(de_w[DE_W-1:0]) : '0;
		res.new_spin = (cmd == CMD_WRITE) ? spin_in : (center ^ res.flip);
	end

endmodule

`default_nettype wire

### design/ising_metropolis_spin_update.sv
// ----------------------------------------------------------------------------
// ising_metropolis_spin_update
// Metropolis spin update engine for a periodic SIDE x SIDE Ising lattice.
// ----------------------------------------------------------------------------
// One request at a time. A write goes from acceptance to ST_DEC, which
// commits it. Read and update fetch the five lattice bits from the
// two-read-port memory in ST_RD1 to ST_RD3 (center and up, down and left,
// right); ST_DEC decides, writes back and loads the result register, which
// frees the input side: a new request is taken while the last result
// still waits. The lattice has no reset; a site never written reads as an
// unknown spin. Row and col are reduced modulo SIDE. The user must write
// thresholds over the cfg channel only while idle; this is not enforced.
`default_nettype none

module ising_metropolis_spin_update
	import ismu_pkg::*;
#(
	parameter int SIDE = SIDE_DEFAULT
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [CMD_W-1:0]  command,
	input  wire logic [POS_W-1:0]  row,
	input  wire logic [POS_W-1:0]  col,
	input  wire logic              spin_in,
	input  wire logic [RAND_W-1:0] rand_u,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   spin_out,
	output logic                   flipped,
	output logic signed [DE_W-1:0] energy_change,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic              cfg_index,
	input  wire logic [THR_W-1:0]  cfg_data
);

	localparam int IW    = $clog2(SIDE);
	localparam int DEPTH = SIDE * SIDE;
	localparam int AW    = $clog2(DEPTH);

	function automatic logic [POS_N*IW-1:0] build_mod();
		logic [POS_N*IW-1:0] tbl;
		int                  r;
		tbl = '0;
		r   = 0;
		for (int i = 0; i < POS_N; i++) begin
			tbl[i*IW +: IW] = IW'(r);
			r = r + 1;
			if (r == SIDE) begin
				r = 0;
			end
		end
		return tbl;
	endfunction

	localparam logic [POS_N*IW-1:0] MOD_TBL = build_mod();

	function automatic logic [AW-1:0] site(input logic [IW-1:0] rr, input logic [IW-1:0] cc);
		return AW'(AW'(rr) * AW'(SIDE)) + AW'(cc);
	endfunction

	state_t state_q, state_d;

	logic [CMD_W-1:0]  cmd_q;
	logic [IW-1:0]     r_q, c_q;
	logic              spin_in_q;
	logic [RAND_W-1:0] rand_q;
	logic [THR_W-1:0]  thr4_q, thr8_q;
	logic              center_q, up_q, dn_q, lf_q;

	logic              out_valid_q;
	logic              spin_out_q;
	logic              flipped_q;
	logic signed [DE_W-1:0] de_q;

	logic [IW-1:0] r_up, r_dn, c_lf, c_rt;
	logic          accept_in, out_free, load;
	logic          mem_re, mem_we;
	logic [AW-1:0] ra_a, ra_b, wa;
	logic          rd_a, rd_b;
	flip_res_t     res;

	assign accept_in = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;

	assign r_up = (r_q == '0) ? IW'(SIDE - 1) : r_q - 1'b1;
	assign r_dn = (r_q == IW'(SIDE - 1)) ? '0 : r_q + 1'b1;
	assign c_lf = (c_q == '0) ? IW'(SIDE - 1) : c_q - 1'b1;
	assign c_rt = (c_q == IW'(SIDE - 1)) ? '0 : c_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		mem_re   = 1'b0;
		ra_a     = site(r_q, c_q);
		ra_b     = site(r_up, c_q);
		load     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = (command == CMD_WRITE) ? ST_DEC : ST_RD1;
				end
			end
			ST_RD1: begin
				mem_re  = 1'b1;
				state_d = ST_RD2;
			end
			ST_RD2: begin
				mem_re  = 1'b1;
				ra_a    = site(r_dn, c_q);
				ra_b    = site(r_q, c_lf);
				state_d = ST_RD3;
			end
			ST_RD3: begin
				mem_re  = 1'b1;
				ra_a    = site(r_q, c_rt);
				ra_b    = site(r_q, c_rt);
				state_d = ST_DEC;
			end
			ST_DEC: begin
				if (out_free) begin
					load    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// commit happens before the next request is taken, so reads never see a stale site
	assign mem_we = load && (cmd_q == CMD_WRITE || res.flip);
	assign wa     = site(r_q, c_q);

	always_ff @(posedge clk) begin
		if (accept_in) begin
			cmd_q     <= command;
			r_q       <= MOD_TBL[row*IW +: IW];
			c_q       <= MOD_TBL[col*IW +: IW];
			spin_in_q <= spin_in;
			rand_q    <= rand_u;
		end
		if (state_q == ST_RD2) begin
			center_q <= rd_a;
			up_q     <= rd_b;
		end
		if (state_q == ST_RD3) begin
			dn_q <= rd_a;
			lf_q <= rd_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr4_q <= THR_DELTA4_RST;
			thr8_q <= THR_DELTA8_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_THR_DELTA4: thr4_q <= cfg_data;
				CFG_THR_DELTA8: thr8_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	ismu_lattice_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk  (clk),
		.re   (mem_re),
		.ra_a (ra_a),
		.ra_b (ra_b),
		.we   (mem_we),
		.wa   (wa),
		.wd   (res.new_spin),
		.rd_a (rd_a),
		.rd_b (rd_b)
	);

	ismu_flip_decide u_decide (
		.cmd     (cmd_q),
		.spin_in (spin_in_q),
		.center  (center_q),
		.up      (up_q),
		.dn      (dn_q),
		.lf      (lf_q),
		.rt      (rd_a),
		.rand_u  (rand_q),
		.thr4    (thr4_q),
		.thr8    (thr8_q),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			spin_out_q <= res.new_spin;
			flipped_q  <= res.flip;
			de_q       <= res.de;
		end
	end

	assign out_valid     = out_valid_q;
	assign spin_out      = spin_out_q;
	assign flipped       = flipped_q;
	assign energy_change = de_q;

	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		accept_in |=> (state_q == ST_RD1 || state_q == ST_DEC))
		else $error("accepted request did not start a sequence");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid)
		else $error("result not presented after commit");

	a_flip_update_only: assert property (@(posedge clk) disable iff (!arst_n)
		(load && res.flip) |-> (cmd_q == CMD_UPDATE))
		else $error("flip on a non-update request");

	a_rw_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(load && cmd_q != CMD_UPDATE) |=> (energy_change == '0 && !flipped))
		else $error("read or write result carries an energy change");

	a_de_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (energy_change[1:0] == 2'b00))
		else $error("energy change not a multiple of four");

endmodule

`default_nettype wire
